[rtl/gbn_pkg.sv]
// Package for the greedy box suppression block: register indexes, threshold reset values and shared widths.
// No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned BoxW   = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegConfThr = 1'd0;
  localparam logic [CfgIdxW-1:0] RegOvlThr  = 1'd1;
  localparam logic [15:0] ConfThrReset = 16'd16384;
  localparam logic [15:0] OvlThrReset  = 16'd29491;
endpackage

[rtl/greedy_box_nms_top.sv]
// Greedy box suppression top level: input capture, kept-box memory scan, IoU test.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
// Usage: boxes enter on the in channel (in_valid_i/in_ready_o) one per item,
// ordered by score within a frame. Each box gives one result item on the
// out channel (out_valid_o/out_ready_i) with keep, below_confidence and
// store_overflow verdicts and an echo of the box.
// A box is compared with the kept boxes one per cycle: the kept-box memory
// has a registered read, and the IoU test is a three-stage pipeline behind
// it; a box with kept boxes to check is scanned, then passes to the output
// register.
// A box cut by confidence, or one that meets an empty store, skips the scan
// and goes from the scan state straight to the output register.
// One box is in work at a time; the next can be taken in the cycle after
// the result is loaded into the output register. This holds even while the
// receiver stalls that result, but the next result then waits until the
// register is free.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and must only be issued while no box is in work. Reset clears the kept
// count and the cut-off flag and loads threshold defaults; the memory needs
// no clearing pass since only entries below the kept count are ever compared.
module greedy_box_nms_top #(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [gbn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic [15:0] box_width_i,
  input  logic [15:0] box_height_i,
  input  logic [15:0] box_score_i,
  input  logic [7:0]  class_label_i,
  input  logic        frame_last_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic keep_o,
  output logic below_confidence_o,
  output logic store_overflow_o,
  output logic signed [15:0] out_center_x_o,
  output logic signed [15:0] out_center_y_o,
  output logic [15:0] out_width_o,
  output logic [15:0] out_height_o,
  output logic [15:0] out_score_o,
  output logic [7:0]  out_class_o,
  output logic        out_last_o
);
  import gbn_pkg::*;
  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CW = $clog2(MAX_KEPT + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_KEPT);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StDone = 3'd3;

  logic [2:0] st_q, st_d;
  logic [15:0] conf_q, ovl_q;
  logic [CW-1:0] cnt_q;
  logic cut_q;
  logic [CW-1:0] rd_q;         // next address to read
  logic [BoxW-1:0] box_q;
  logic [15:0] score_q;
  logic [7:0] cls_q;
  logic last_q;
  logic sup_q;
  logic [BoxW-1:0] mem [MAX_KEPT];
  logic [BoxW-1:0] rdata_q;
  logic v0_q, v1_q, v2_q, v3_q; // pipeline valid bits

  // result register
  logic ov_q;
  logic keep_q, below_q, over_q;
  logic [BoxW-1:0] obox_q;
  logic [15:0] oscore_q;
  logic [7:0] ocls_q;
  logic olast_q;

  assign in_ready_o = (st_q == StIdle);
  wire in_acc = in_valid_i && in_ready_o;
  wire out_free = !ov_q || out_ready_i;
  wire load_out = (st_q == StDone) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= ConfThrReset;
      ovl_q  <= OvlThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegConfThr: conf_q <= cfg_data_i;
        RegOvlThr:  ovl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory: one write, one registered read
  wire wr_en = load_out && !cut_q && !sup_q && (cnt_q < MaxCnt);
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[AW-1:0]] <= box_q;
    rdata_q <= mem[rd_q[AW-1:0]];
  end

  // IoU pipeline, stage 1: edges and overlap widths
  logic signed [18:0] s1_iw_q, s1_ih_q;
  logic [31:0] s1_aw_q, s1_ah_q; // holds w,h of both
  logic [15:0] aw, ah, bw, bh;
  logic signed [18:0] al, ar, at, ab, bl, br, bt, bb;
  always_comb begin
    aw = rdata_q[47:32]; ah = rdata_q[63:48];
    bw = box_q[47:32];   bh = box_q[63:48];
    al = (19'(signed'(rdata_q[15:0])) <<< 1) - signed'(19'(aw));
    ar = (19'(signed'(rdata_q[15:0])) <<< 1) + signed'(19'(aw));
    at = (19'(signed'(rdata_q[31:16])) <<< 1) - signed'(19'(ah));
    ab = (19'(signed'(rdata_q[31:16])) <<< 1) + signed'(19'(ah));
    bl = (19'(signed'(box_q[15:0])) <<< 1) - signed'(19'(bw));
    br = (19'(signed'(box_q[15:0])) <<< 1) + signed'(19'(bw));
    bt = (19'(signed'(box_q[31:16])) <<< 1) - signed'(19'(bh));
    bb = (19'(signed'(box_q[31:16])) <<< 1) + signed'(19'(bh));
  end
  always_ff @(posedge clk_i) begin
    s1_iw_q <= ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
    s1_ih_q <= ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
    s1_aw_q <= {aw, bw};
    s1_ah_q <= {ah, bh};
  end
  // stage 2: products
  logic [35:0] s2_int_q;
  logic [31:0] s2_aa_q, s2_ab_q;
  always_ff @(posedge clk_i) begin
    if (s1_iw_q > 0 && s1_ih_q > 0)
      s2_int_q <= 36'(unsigned'(s1_iw_q[17:0])) * 36'(unsigned'(s1_ih_q[17:0]));
    else
      s2_int_q <= '0;
    s2_aa_q <= s1_aw_q[31:16] * s1_ah_q[31:16];
    s2_ab_q <= s1_aw_q[15:0] * s1_ah_q[15:0];
  end
  // stage 3: union and threshold multiply, split in two 18 by 16 products
  logic [35:0] union4;
  logic [51:0] s3_lhs_q, s3_rhs;
  assign union4 = ({s2_aa_q, 2'b00} + {s2_ab_q, 2'b00}) - s2_int_q[35:0];
  logic [33:0] s3_plo_q, s3_phi_q;
  always_ff @(posedge clk_i) begin
    s3_lhs_q <= {s2_int_q, 16'd0};
    s3_plo_q <= union4[17:0] * ovl_q;
    s3_phi_q <= union4[35:18] * ovl_q;
  end
  assign s3_rhs = 52'(s3_plo_q) + {s3_phi_q, 18'd0};
  wire hit = s3_lhs_q > s3_rhs;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (in_acc) st_d = StScan;
      StScan:  if (sup_q || (rd_q >= cnt_q && !v0_q && !v1_q && !v2_q && !v3_q)
                   || cut_q) st_d = StDone;
      StDrain: st_d = StDone;
      StDone:  if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  wire scan_issue = (st_q == StScan) && !sup_q && !cut_q && (rd_q < cnt_q);
  wire scan_end = (st_q == StScan) && (st_d == StDone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; cut_q <= 1'b0; rd_q <= '0; sup_q <= 1'b0;
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (scan_end) begin
        v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      end else begin
        v0_q <= scan_issue;
        v1_q <= v0_q && !sup_q; v2_q <= v1_q && !sup_q; v3_q <= v2_q && !sup_q;
      end
      if (in_acc) rd_q <= '0;
      else if (scan_issue) rd_q <= rd_q + 1'b1;
      if (in_acc) sup_q <= 1'b0;
      else if ((st_q == StScan) && v3_q && hit) sup_q <= 1'b1;
      if (in_acc) cut_q <= cut_q || (box_score_i < conf_q);
      else if (load_out && last_q) cut_q <= 1'b0;
      if (load_out && last_q) cnt_q <= '0;
      else if (wr_en) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      box_q <= {box_height_i, box_width_i, center_y_i, center_x_i};
      score_q <= box_score_i; cls_q <= class_label_i; last_q <= frame_last_i;
    end
    if (load_out) begin
      keep_q <= wr_en;
      below_q <= cut_q;
      over_q <= !cut_q && !sup_q && (cnt_q >= MaxCnt);
      obox_q <= box_q; oscore_q <= score_q; ocls_q <= cls_q; olast_q <= last_q;
    end
  end

  assign out_valid_o = ov_q;
  assign keep_o = keep_q;
  assign below_confidence_o = below_q;
  assign store_overflow_o = over_q;
  assign out_center_x_o = signed'(obox_q[15:0]);
  assign out_center_y_o = signed'(obox_q[31:16]);
  assign out_width_o = obox_q[47:32];
  assign out_height_o = obox_q[63:48];
  assign out_score_o = oscore_q;
  assign out_class_o = ocls_q;
  assign out_last_o = olast_q;
endmodule

[rtl/greedy_box_nms_chk.sv]
// Port-level checker for the greedy box suppression block, bound to the top level.
// Depends on greedy_box_nms_top.
`timescale 1ns / 1ps
module greedy_box_nms_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic keep_o,
  input logic below_confidence_o,
  input logic store_overflow_o,
  input logic out_last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(keep_o) && $stable(out_last_o))
    else $error("result changed while stalled");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({keep_o, below_confidence_o, store_overflow_o}))
    else $error("verdict flags not exclusive");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && store_overflow_o && !out_last_o
      ##1 out_valid_o && !below_confidence_o |-> !keep_o)
    else $error("box kept after overflow in same frame");
endmodule

bind greedy_box_nms_top greedy_box_nms_chk u_chk (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for greedy_box_nms_top: frames of boxes with random idling,
// checked against an in-bench model of greedy IoU suppression. Depends on gbn_pkg and greedy_box_nms_top.
`timescale 1ns / 1ps
module tb_top;
  import gbn_pkg::*;

  localparam int unsigned MaxKept = 64;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [7:0]  cls;
    logic        last;
  } box_t;

  typedef struct packed {
    logic keep;
    logic below;
    logic overflow;
    box_t box;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegConfThr;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  box_t drv_box = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic keep_o, below_confidence_o, store_overflow_o, out_last_o;
  logic signed [15:0] out_center_x_o, out_center_y_o;
  logic [15:0] out_width_o, out_height_o, out_score_o;
  logic [7:0] out_class_o;

  greedy_box_nms_top #(.MAX_KEPT(MaxKept)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .center_x_i(drv_box.cx), .center_y_i(drv_box.cy),
    .box_width_i(drv_box.w), .box_height_i(drv_box.h),
    .box_score_i(drv_box.score), .class_label_i(drv_box.cls),
    .frame_last_i(drv_box.last),
    .out_valid_o, .out_ready_i, .keep_o, .below_confidence_o, .store_overflow_o,
    .out_center_x_o, .out_center_y_o, .out_width_o, .out_height_o,
    .out_score_o, .out_class_o, .out_last_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  box_t pending_boxes[$];
  verdict_t expected_verdicts[$];
  int unsigned fail_count = 0;
  bit calm = 1'b0;

  // Model of the suppression state.
  logic [63:0] kept_boxes[MaxKept];
  int unsigned kept_n = 0;
  bit cut_seen = 1'b0;
  logic [15:0] conf_thr = ConfThrReset;
  logic [15:0] ovl_thr = OvlThrReset;

  // Edges at twice the resolution keep the half sizes exact; all terms are 4x.
  function automatic bit iou_above(logic [63:0] a, logic [63:0] b, logic [15:0] thr);
    longint ax, ay, aw, ah, bx, by, bw, bh, lft, rgt, top_e, bot_e, iw, ih;
    longint unsigned inter4, union4;
    ax = longint'($signed(a[15:0]));
    ay = longint'($signed(a[31:16]));
    aw = longint'(a[47:32]);
    ah = longint'(a[63:48]);
    bx = longint'($signed(b[15:0]));
    by = longint'($signed(b[31:16]));
    bw = longint'(b[47:32]);
    bh = longint'(b[63:48]);
    lft = (2 * ax - aw > 2 * bx - bw) ? 2 * ax - aw : 2 * bx - bw;
    rgt = (2 * ax + aw < 2 * bx + bw) ? 2 * ax + aw : 2 * bx + bw;
    top_e = (2 * ay - ah > 2 * by - bh) ? 2 * ay - ah : 2 * by - bh;
    bot_e = (2 * ay + ah < 2 * by + bh) ? 2 * ay + ah : 2 * by + bh;
    iw = rgt - lft;
    ih = bot_e - top_e;
    inter4 = (iw > 0 && ih > 0) ? longint'(iw * ih) : 0;
    union4 = 4 * aw * ah + 4 * bw * bh - inter4;
    return inter4 * 65536 > longint'(thr) * union4;
  endfunction

  function automatic verdict_t judge_box(box_t b);
    verdict_t v;
    logic [63:0] packed_box;
    bit suppressed;
    v = '0;
    v.box = b;
    packed_box = {b.h, b.w, b.cy, b.cx};
    suppressed = 1'b0;
    if (cut_seen || b.score < conf_thr) begin
      cut_seen = 1'b1;
      v.below = 1'b1;
    end else begin
      for (int unsigned i = 0; i < kept_n && !suppressed; i++)
        suppressed = iou_above(kept_boxes[i], packed_box, ovl_thr);
      if (!suppressed) begin
        if (kept_n < MaxKept) begin
          kept_boxes[kept_n] = packed_box;
          kept_n++;
          v.keep = 1'b1;
        end else begin
          v.overflow = 1'b1;
        end
      end
    end
    if (b.last) begin
      kept_n = 0;
      cut_seen = 1'b0;
    end
    return v;
  endfunction

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(9, 0);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Driver: at most one nonblocking assignment to valid per edge.
  int unsigned in_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_verdicts = {expected_verdicts, judge_box(drv_box)};
        in_wait = draw_wait();
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_boxes.size() > 0) begin
          drv_box <= pending_boxes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result item with the oldest expectation.
  int unsigned out_wait = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report("unexpected item", out_center_x_o, 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (keep_o !== want.keep) report("keep", keep_o, want.keep);
          if (below_confidence_o !== want.below)
            report("below_confidence", below_confidence_o, want.below);
          if (store_overflow_o !== want.overflow)
            report("store_overflow", store_overflow_o, want.overflow);
          if (out_center_x_o !== want.box.cx) report("center_x", out_center_x_o, want.box.cx);
          if (out_center_y_o !== want.box.cy) report("center_y", out_center_y_o, want.box.cy);
          if (out_width_o !== want.box.w) report("width", out_width_o, want.box.w);
          if (out_height_o !== want.box.h) report("height", out_height_o, want.box.h);
          if (out_score_o !== want.box.score) report("score", out_score_o, want.box.score);
          if (out_class_o !== want.box.cls) report("class", out_class_o, want.box.cls);
          if (out_last_o !== want.box.last) report("last", out_last_o, want.box.last);
        end
        out_wait = draw_wait();
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_box(logic [15:0] cx, logic [15:0] cy, logic [15:0] w, logic [15:0] h,
                         logic [15:0] score, logic [7:0] cls, logic last);
    box_t b;
    b = '{cx: cx, cy: cy, w: w, h: h, score: score, cls: cls, last: last};
    pending_boxes = {pending_boxes, b};
  endtask

  // A well-formed frame: mostly descending scores around a few clusters, so IoU lands on
  // both sides of the threshold; the score tail may fall under the cut-off.
  task automatic add_cluster_frame(int unsigned n);
    int unsigned s;
    int cx0, cy0;
    s = $urandom_range(65535, 30000);
    cx0 = $urandom_range(4000, 0) - 2000;
    cy0 = $urandom_range(4000, 0) - 2000;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(3, 0) == 0) begin
        cx0 = $urandom_range(4000, 0) - 2000;
        cy0 = $urandom_range(4000, 0) - 2000;
      end
      add_box(16'(cx0 + int'($urandom_range(200, 0)) - 100),
              16'(cy0 + int'($urandom_range(200, 0)) - 100),
              16'($urandom_range(800, 100)), 16'($urandom_range(800, 100)),
              16'(s), 8'($urandom), i == n - 1);
      s = (s > 3000) ? s - $urandom_range(3000, 0) : 0;
      if ($urandom_range(15, 0) == 0) s = $urandom; // out of order now and then
    end
  endtask

  // Disjoint boxes on a grid: up to MaxKept are kept and any later boxes overflow.
  task automatic add_grid_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_box(16'((i % 16) * 512 - 4096), 16'((i / 16) * 512 - 2048),
              16'($urandom_range(400, 1)), 16'($urandom_range(400, 1)),
              16'(65535 - i), 8'($urandom), i == n - 1);
  endtask

  task automatic add_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom), $urandom_range(7, 0) == 0);
  endtask

  // Checked on the falling edge, when every update of the rising edge has settled.
  task automatic wait_idle(int unsigned tail);
    do @(negedge clk_i);
    while (pending_boxes.size() != 0 || expected_verdicts.size() != 0 || in_valid_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == RegConfThr) conf_thr = data;
    else ovl_thr = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned target);
    int unsigned goal;
    goal = pending_boxes.size() + target;
    while (pending_boxes.size() < goal) begin
      case ($urandom_range(9, 0))
        0: add_grid_frame($urandom_range(72, 60));
        1, 2: add_noise($urandom_range(12, 1));
        default: add_cluster_frame($urandom_range(24, 1));
      endcase
    end
    calm = ($urandom_range(3, 0) == 0);
    wait_idle(10);
  endtask

  logic [15:0] conf_set[6] = '{16'd0, 16'd65535, 16'd1000, 16'd0, 16'd40000, 16'd8000};
  logic [15:0] ovl_set[6]  = '{16'd0, 16'd65535, 16'd32768, 16'd65535, 16'd16384, 16'd0};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame under reset thresholds: extremes, zero-area pair, unsorted
    // scores, a duplicate box, then the cut-off that holds to the frame end.
    add_box(16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 8'hff, 1'b0);
    add_box(16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hfff0, 8'h00, 1'b0);
    add_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hff00, 8'h01, 1'b0);
    add_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hfe00, 8'h02, 1'b0);
    add_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'h5000, 8'h03, 1'b0);
    add_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'hf000, 8'h04, 1'b0);
    add_box(16'h0108, 16'h0100, 16'h0040, 16'h0040, 16'h9000, 8'h05, 1'b0);
    add_box(16'hff00, 16'h0200, 16'h0010, 16'h0000, 16'h4000, 8'h06, 1'b0);
    add_box(16'h0400, 16'h0400, 16'h0020, 16'h0020, 16'h3fff, 8'h07, 1'b0);
    add_box(16'h0500, 16'h0500, 16'h0020, 16'h0020, 16'hffff, 8'h08, 1'b0);
    add_box(16'h0600, 16'h0600, 16'h0020, 16'h0020, 16'h0000, 8'h09, 1'b1);
    // Next frame must start clean.
    add_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'h8000, 8'h0a, 1'b0);
    add_box(16'h0100, 16'h0100, 16'h0040, 16'h0040, 16'h7000, 8'h0b, 1'b1);
    wait_idle(10);

    run_random(150);
    for (int p = 0; p < 6; p++) begin
      write_reg(RegConfThr, conf_set[p]);
      write_reg(RegOvlThr, ovl_set[p]);
      if (p == 5) begin
        write_reg(RegConfThr, 16'($urandom));
        write_reg(RegOvlThr, 16'($urandom));
      end
      run_random(p == 0 ? 100 : 170);
    end

    wait_idle(80);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

[files.f]
rtl/gbn_pkg.sv
rtl/greedy_box_nms_top.sv
rtl/greedy_box_nms_chk.sv
tb/sv/tb_top.sv
